// ----- hdl/poly_multiply_convolution_assert.svh -----
// Assertion macros shared by the polynomial multiplier RTL.
`ifndef POLY_MULTIPLY_CONVOLUTION_ASSERT_SVH
`define POLY_MULTIPLY_CONVOLUTION_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define PMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pmc_pkg.sv -----
// Package with shared types and constants of the polynomial multiplier.
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

    // Fixed field widths of the request and result ports.
    localparam int OP_W  = 2;
    localparam int IN_W  = 16;
    localparam int ACC_W = 36;

    // Defaults of the top-level parameters.
    localparam int MAX_TERMS_DEF   = 16;
    localparam int COEFF_WIDTH_DEF = 16;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_P = 2'd0,
        OP_LOAD_Q = 2'd1,
        OP_MUL    = 2'd2
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR,
        ST_DRAIN
    } t_state;

    // Tags that travel with one product term through the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last_term;
        logic last_res;
        logic err;
        logic ovf;
    } t_term;

endpackage

`default_nettype wire

// ----- hdl/pmc_coeff_store.sv -----
// Coefficient memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pmc_coeff_store #(
    parameter int DEPTH = pmc_pkg::MAX_TERMS_DEF,
    parameter int WIDTH = pmc_pkg::COEFF_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/pmc_mac.sv -----
// Shared multiply-accumulate unit: read stage, product register, accumulator.
`timescale 1ns / 1ps
`default_nettype none

module pmc_mac #(
    parameter int COEFF_WIDTH = pmc_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pmc_pkg::t_term                  i_term,
    input  wire logic        [COEFF_WIDTH-1:0]   i_p_data,
    input  wire logic        [COEFF_WIDTH-1:0]   i_q_data,
    output logic                                 o_valid,
    output logic signed      [pmc_pkg::ACC_W-1:0] o_coeff_out,
    output logic                                 o_last,
    output logic                                 o_error,
    output logic                                 o_overflow
);

    localparam int PW = 2 * COEFF_WIDTH;

    pmc_pkg::t_term                    r_tag1;
    pmc_pkg::t_term                    r_tag2;
    logic signed [PW-1:0]              r_prod;
    logic signed [pmc_pkg::ACC_W-1:0]  r_acc;
    logic signed [PW-1:0]              w_prod;
    logic signed [pmc_pkg::ACC_W-1:0]  w_prod_ext;
    logic signed [pmc_pkg::ACC_W-1:0]  n_acc;

    // Tags follow the memory read and the product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_term;
            r_tag2 <= r_tag1;
        end
    end

    // One signed multiply per cycle; an error term contributes zero.
    assign w_prod = $signed(i_p_data) * $signed(i_q_data);

    always_ff @(posedge i_clk) begin
        if (r_tag1.err) begin
            r_prod <= '0;
        end else begin
            r_prod <= w_prod;
        end
    end

    // Accumulate into 36 bits, wrapping; the first term of a sum restarts it.
    assign w_prod_ext = pmc_pkg::ACC_W'(r_prod);
    assign n_acc      = r_tag2.first ? w_prod_ext : r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
    end

    // Result register, strobed when the last term of a sum is in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_tag2.valid && r_tag2.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag2.valid && r_tag2.last_term) begin
            o_coeff_out <= n_acc;
            o_last      <= r_tag2.last_res;
            o_error     <= r_tag2.err;
            o_overflow  <= r_tag2.ovf;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pmc_seq.sv -----
// Sequencer: load counts, overflow flag and the walk over product terms.
`timescale 1ns / 1ps
`default_nettype none

module pmc_seq #(
    parameter int MAX_TERMS = pmc_pkg::MAX_TERMS_DEF,
    localparam int IDX_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [pmc_pkg::OP_W-1:0]  i_op,
    input  wire logic                      i_done,
    output logic                           o_busy,
    output logic                           o_p_we,
    output logic                           o_q_we,
    output logic      [IDX_W-1:0]          o_p_waddr,
    output logic      [IDX_W-1:0]          o_q_waddr,
    output logic      [IDX_W-1:0]          o_p_raddr,
    output logic      [IDX_W-1:0]          o_q_raddr,
    output pmc_pkg::t_term                 o_term
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int K_W   = $clog2(2 * MAX_TERMS);
    localparam int EW    = K_W + 1;

    pmc_pkg::t_state  r_state;
    pmc_pkg::t_state  n_state;
    logic [CNT_W-1:0] r_p_cnt;
    logic [CNT_W-1:0] r_q_cnt;
    logic             r_drop;
    logic [CNT_W-1:0] r_np;
    logic [CNT_W-1:0] r_nq;
    logic [K_W-1:0]   r_k;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic             r_first;
    logic             r_ovf;

    logic             w_accept;
    logic             w_mul;
    logic             w_empty;
    logic [EW-1:0]    w_k_e;
    logic [EW-1:0]    w_np_e;
    logic [EW-1:0]    w_nq_e;
    logic [EW-1:0]    w_i_hi;
    logic [EW-1:0]    w_kn;
    logic [EW-1:0]    w_i_lo_n;
    logic [EW-1:0]    w_j0_n;
    logic             w_last_term;
    logic             w_last_res;

    assign w_accept = i_start && (r_state == pmc_pkg::ST_IDLE);
    assign w_mul    = w_accept && (i_op == pmc_pkg::OP_MUL);
    assign w_empty  = (r_p_cnt == '0) || (r_q_cnt == '0);

    // Bounds of the term walk for the current and the next result.
    assign w_k_e       = EW'(r_k);
    assign w_np_e      = EW'(r_np);
    assign w_nq_e      = EW'(r_nq);
    assign w_i_hi      = (w_k_e < w_np_e) ? w_k_e : w_np_e - 1'b1;
    assign w_last_term = (EW'(r_i) == w_i_hi);
    assign w_last_res  = w_last_term && (w_k_e == w_np_e + w_nq_e - 2'd2);
    assign w_kn        = w_k_e + 1'b1;
    assign w_i_lo_n    = (w_kn >= w_nq_e) ? w_kn - w_nq_e + 1'b1 : '0;
    assign w_j0_n      = (w_kn >= w_nq_e) ? w_nq_e - 1'b1 : w_kn;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmc_pkg::ST_IDLE: begin
                if (w_mul) begin
                    n_state = w_empty ? pmc_pkg::ST_ERR : pmc_pkg::ST_RUN;
                end
            end
            pmc_pkg::ST_RUN: begin
                if (w_last_res) begin
                    n_state = pmc_pkg::ST_DRAIN;
                end
            end
            pmc_pkg::ST_ERR: begin
                n_state = pmc_pkg::ST_DRAIN;
            end
            pmc_pkg::ST_DRAIN: begin
                if (i_done) begin
                    n_state = pmc_pkg::ST_IDLE;
                end
            end
            default: n_state = pmc_pkg::ST_IDLE;
        endcase
    end

    // Outputs: store writes, read addresses and the tags of the issued term.
    always_comb begin
        o_busy         = 1'b1;
        o_term         = '0;
        o_term.ovf     = r_ovf;
        unique case (r_state)
            pmc_pkg::ST_IDLE: begin
                o_busy = 1'b0;
            end
            pmc_pkg::ST_RUN: begin
                o_term.valid     = 1'b1;
                o_term.first     = r_first;
                o_term.last_term = w_last_term;
                o_term.last_res  = w_last_res;
            end
            pmc_pkg::ST_ERR: begin
                o_term.valid     = 1'b1;
                o_term.first     = 1'b1;
                o_term.last_term = 1'b1;
                o_term.last_res  = 1'b1;
                o_term.err       = 1'b1;
            end
            pmc_pkg::ST_DRAIN: begin
                o_busy = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

    assign o_p_we    = w_accept && (i_op == pmc_pkg::OP_LOAD_P) &&
                       (r_p_cnt != CNT_W'(MAX_TERMS));
    assign o_q_we    = w_accept && (i_op == pmc_pkg::OP_LOAD_Q) &&
                       (r_q_cnt != CNT_W'(MAX_TERMS));
    assign o_p_waddr = r_p_cnt[IDX_W-1:0];
    assign o_q_waddr = r_q_cnt[IDX_W-1:0];
    assign o_p_raddr = r_i;
    assign o_q_raddr = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load counts and the sticky drop flag; a multiply clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_cnt <= '0;
            r_q_cnt <= '0;
            r_drop  <= 1'b0;
        end else if (w_accept) begin
            case (i_op)
                pmc_pkg::OP_LOAD_P: begin
                    if (o_p_we) begin
                        r_p_cnt <= r_p_cnt + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                pmc_pkg::OP_LOAD_Q: begin
                    if (o_q_we) begin
                        r_q_cnt <= r_q_cnt + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                pmc_pkg::OP_MUL: begin
                    r_p_cnt <= '0;
                    r_q_cnt <= '0;
                    r_drop  <= 1'b0;
                end
                default: r_drop <= r_drop;
            endcase
        end
    end

    // Walk indexes: k is the result, i runs over p and j over q with i+j=k.
    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_np    <= r_p_cnt;
            r_nq    <= r_q_cnt;
            r_ovf   <= r_drop;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_first <= 1'b1;
        end else if (r_state == pmc_pkg::ST_RUN) begin
            if (w_last_term) begin
                r_k     <= w_kn[K_W-1:0];
                r_i     <= w_i_lo_n[IDX_W-1:0];
                r_j     <= w_j0_n[IDX_W-1:0];
                r_first <= 1'b1;
            end else begin
                r_i     <= r_i + 1'b1;
                r_j     <= r_j - 1'b1;
                r_first <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/poly_multiply_convolution.sv -----
// Top level of the integer polynomial multiplier (linear convolution).
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_start, o_busy           i_op, i_coeff_in
//   result    out        o_valid (one-cycle strobe) o_coeff_out, o_last, o_error, o_overflow
//
// A load request leaves the block idle; the next request can follow directly.
// A multiply issues one product term per cycle through a single shared
// multiply-accumulate unit and holds o_busy, also with an empty operand,
// until its last result has left. A result passes the store read, the
// product register and the result register after its last term is issued.
// Reset is synchronous and clears counts, flags and the sequencer.
// The receiver cannot stall: every result is on the ports for one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "poly_multiply_convolution_assert.svh"

module poly_multiply_convolution #(
    parameter int MAX_TERMS   = pmc_pkg::MAX_TERMS_DEF,
    parameter int COEFF_WIDTH = pmc_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic        [pmc_pkg::OP_W-1:0]   i_op,
    input  wire logic signed [pmc_pkg::IN_W-1:0]   i_coeff_in,
    output logic                                   o_valid,
    output logic signed      [pmc_pkg::ACC_W-1:0]  o_coeff_out,
    output logic                                   o_last,
    output logic                                   o_error,
    output logic                                   o_overflow
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int NW    = (COEFF_WIDTH < pmc_pkg::IN_W) ? COEFF_WIDTH : pmc_pkg::IN_W;

    logic                   w_p_we;
    logic                   w_q_we;
    logic [IDX_W-1:0]       w_p_waddr;
    logic [IDX_W-1:0]       w_q_waddr;
    logic [IDX_W-1:0]       w_p_raddr;
    logic [IDX_W-1:0]       w_q_raddr;
    logic [COEFF_WIDTH-1:0] w_wdata;
    logic [COEFF_WIDTH-1:0] w_p_data;
    logic [COEFF_WIDTH-1:0] w_q_data;
    pmc_pkg::t_term         w_term;
    logic                   w_done;

    // Narrow the coefficient to the stored width and sign-extend it back.
    assign w_wdata = COEFF_WIDTH'($signed(i_coeff_in[NW-1:0]));

    assign w_done = o_valid && o_last;

    pmc_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_op      (i_op),
        .i_done    (w_done),
        .o_busy    (o_busy),
        .o_p_we    (w_p_we),
        .o_q_we    (w_q_we),
        .o_p_waddr (w_p_waddr),
        .o_q_waddr (w_q_waddr),
        .o_p_raddr (w_p_raddr),
        .o_q_raddr (w_q_raddr),
        .o_term    (w_term)
    );

    pmc_coeff_store #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_WIDTH)
    ) u_p_store (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_data)
    );

    pmc_coeff_store #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_WIDTH)
    ) u_q_store (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_data)
    );

    pmc_mac #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_term      (w_term),
        .i_p_data    (w_p_data),
        .i_q_data    (w_q_data),
        .o_valid     (o_valid),
        .o_coeff_out (o_coeff_out),
        .o_last      (o_last),
        .o_error     (o_error),
        .o_overflow  (o_overflow)
    );

    // Results only appear while a multiply is still in progress.
    `PMC_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, o_busy, "result outside a multiply")
    // An accepted multiply always makes the block busy.
    `PMC_ASSERT_NEXT(a_mul_busy, i_clk, i_rst_n, i_start && !o_busy && (i_op == pmc_pkg::OP_MUL), o_busy, "multiply not started")
    // An empty-operand result is a single, final one.
    `PMC_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, o_valid && o_error, o_last, "error result not last")
    // An empty-operand result carries a zero coefficient.
    `PMC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_error, o_coeff_out == '0, "error result not zero")

endmodule

`default_nettype wire

// ----- dv/tb_poly_multiply_convolution.sv -----
// Self-checking testbench for the polynomial multiplier: directed and randomized requests against a predictor.
`timescale 1ns / 1ps

module tb_poly_multiply_convolution;

    localparam int OP_W           = pmc_pkg::OP_W;
    localparam int IN_W           = pmc_pkg::IN_W;
    localparam int ACC_W          = pmc_pkg::ACC_W;
    localparam int MAX_TERMS      = pmc_pkg::MAX_TERMS_DEF;
    localparam int COEFF_WIDTH    = pmc_pkg::COEFF_WIDTH_DEF;
    localparam int NARROW_W       = (COEFF_WIDTH < IN_W) ? COEFF_WIDTH : IN_W;
    localparam int NARROW_SHIFT   = IN_W - NARROW_W;
    localparam int RANDOM_ITEMS   = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    // Op code that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]        op;
        logic signed [IN_W-1:0] coeff;
    } t_request;

    typedef struct {
        logic signed [ACC_W-1:0] coeff;
        logic                    last;
        logic                    err;
        logic                    ovf;
    } t_product_term;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic [OP_W-1:0]         i_op;
    logic signed [IN_W-1:0]  i_coeff_in;
    logic                    o_valid;
    logic signed [ACC_W-1:0] o_coeff_out;
    logic                    o_last;
    logic                    o_error;
    logic                    o_overflow;

    t_request      pending_requests[$];
    t_product_term expected_terms[$];

    // Predictor copy of the operand stores.
    logic signed [IN_W-1:0] p_coef[MAX_TERMS];
    logic signed [IN_W-1:0] q_coef[MAX_TERMS];
    int                     p_len;
    int                     q_len;
    bit                     loads_dropped;

    bit req_taken;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;

    poly_multiply_convolution #(
        .MAX_TERMS   (MAX_TERMS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_op        (i_op),
        .i_coeff_in  (i_coeff_in),
        .o_valid     (o_valid),
        .o_coeff_out (o_coeff_out),
        .o_last      (o_last),
        .o_error     (o_error),
        .o_overflow  (o_overflow)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Wraps a load coefficient to the stored width, sign preserved.
    function automatic logic signed [IN_W-1:0] narrow_coeff(input logic signed [IN_W-1:0] raw);
        logic signed [IN_W-1:0] shifted;
        shifted = raw <<< NARROW_SHIFT;
        return shifted >>> NARROW_SHIFT;
    endfunction

    // Updates the predictor for one accepted request and queues the products it causes.
    task automatic predict_product(input t_request req);
        t_product_term term;
        longint        acc;
        int            total;
        if (req.op == pmc_pkg::OP_LOAD_P || req.op == pmc_pkg::OP_LOAD_Q) begin
            if (req.op == pmc_pkg::OP_LOAD_P) begin
                if (p_len >= MAX_TERMS) loads_dropped = 1'b1;
                else p_coef[p_len++] = narrow_coeff(req.coeff);
            end else begin
                if (q_len >= MAX_TERMS) loads_dropped = 1'b1;
                else q_coef[q_len++] = narrow_coeff(req.coeff);
            end
        end else if (req.op == pmc_pkg::OP_MUL) begin
            if (p_len == 0 || q_len == 0) begin
                term.coeff = '0;
                term.last  = 1'b1;
                term.err   = 1'b1;
                term.ovf   = loads_dropped;
                expected_terms.push_back(term);
            end else begin
                total = p_len + q_len - 1;
                for (int k = 0; k < total; k++) begin
                    acc = 0;
                    for (int i = 0; i < p_len; i++) begin
                        if (k >= i && (k - i) < q_len)
                            acc += longint'(p_coef[i]) * longint'(q_coef[k - i]);
                    end
                    term.coeff = acc[ACC_W-1:0];
                    term.last  = (k == total - 1);
                    term.err   = 1'b0;
                    term.ovf   = loads_dropped;
                    expected_terms.push_back(term);
                end
            end
            p_len         = 0;
            q_len         = 0;
            loads_dropped = 1'b0;
        end
    endtask

    // Request driver: holds each request until taken, bursts and gaps between them.
    always @(negedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !req_taken) begin
            // Request still waiting for the block.
        end else begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                i_op       <= req.op;
                i_coeff_in <= req.coeff;
                i_start    <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each result strobe.
    always @(posedge i_clk) begin
        t_request      req;
        t_product_term exp_term;
        bit            activity;
        activity = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                req.op    = i_op;
                req.coeff = i_coeff_in;
                predict_product(req);
                req_taken = 1'b1;
                activity  = 1'b1;
            end
            if (o_valid) begin
                activity = 1'b1;
                if (expected_terms.size() == 0) begin
                    report_mismatch($sformatf("unexpected result coeff=%0d last=%0b",
                                              o_coeff_out, o_last));
                end else begin
                    exp_term = expected_terms.pop_front();
                    if (o_coeff_out !== exp_term.coeff)
                        report_mismatch($sformatf("coeff_out got %0d exp %0d",
                                                  o_coeff_out, exp_term.coeff));
                    if (o_last !== exp_term.last)
                        report_mismatch($sformatf("last got %0b exp %0b",
                                                  o_last, exp_term.last));
                    if (o_error !== exp_term.err)
                        report_mismatch($sformatf("error got %0b exp %0b",
                                                  o_error, exp_term.err));
                    if (o_overflow !== exp_term.ovf)
                        report_mismatch($sformatf("overflow got %0b exp %0b",
                                                  o_overflow, exp_term.ovf));
                end
            end
            idle_cycles = activity ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any request or result.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Queues one request.
    task automatic push_request(input logic [OP_W-1:0] op, input logic signed [IN_W-1:0] coeff);
        t_request req;
        req.op    = op;
        req.coeff = coeff;
        pending_requests.push_back(req);
    endtask

    // Random coefficient, weighted toward the extremes and zero.
    function automatic logic signed [IN_W-1:0] pick_coeff();
        int          sel;
        logic [31:0] rnd;
        sel = $urandom_range(0, 15);
        rnd = $urandom;
        if (sel < 2) return 16'sh8000;
        if (sel < 4) return 16'sh7FFF;
        if (sel == 4) return '0;
        return rnd[IN_W-1:0];
    endfunction

    // Operand length: mostly small, sometimes full or past full.
    function automatic int pick_len();
        if ($urandom_range(0, 3) != 0) return $urandom_range(1, 4);
        return $urandom_range(1, MAX_TERMS + 2);
    endfunction

    // Stimulus, run sequencing and the final verdict.
    initial begin
        int  random_count;
        int  np;
        int  nq;
        int  kind;
        bit  to_p;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_op          = pmc_pkg::OP_LOAD_P;
        i_coeff_in    = '0;
        req_taken     = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        gap_left      = 0;
        p_len         = 0;
        q_len         = 0;
        loads_dropped = 1'b0;
        random_count  = 0;
        foreach (p_coef[i]) p_coef[i] = '0;
        foreach (q_coef[i]) q_coef[i] = '0;

        // Directed: both operands empty.
        push_request(pmc_pkg::OP_MUL, '0);
        // Directed: q empty, with an ignored op in between.
        push_request(pmc_pkg::OP_LOAD_P, 16'sh7FFF);
        push_request(OP_UNUSED, 16'sh7FFF);
        push_request(pmc_pkg::OP_MUL, '0);
        // Directed: p empty.
        push_request(pmc_pkg::OP_LOAD_Q, 16'sh7FFF);
        push_request(pmc_pkg::OP_MUL, '0);
        // Directed: p store overfilled at the negative extreme, times a single term.
        for (int i = 0; i < MAX_TERMS + 1; i++) push_request(pmc_pkg::OP_LOAD_P, 16'sh8000);
        push_request(pmc_pkg::OP_LOAD_Q, 16'sh8000);
        push_request(pmc_pkg::OP_MUL, 16'sh7FFF);

        // Random: mostly well-formed operand sets followed by a multiply.
        while (random_count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                np = pick_len();
                nq = pick_len();
            end else begin
                // Broken set: one or both operands left empty.
                np = ($urandom_range(0, 1) == 0) ? 0 : pick_len();
                nq = (np != 0 || $urandom_range(0, 1) == 0) ? 0 : pick_len();
            end
            while (np > 0 || nq > 0) begin
                if ($urandom_range(0, 14) == 0) push_request(OP_UNUSED, pick_coeff());
                to_p = (nq == 0) || (np > 0 && $urandom_range(0, 1) == 0);
                push_request(to_p ? pmc_pkg::OP_LOAD_P : pmc_pkg::OP_LOAD_Q, pick_coeff());
                if (to_p) np--;
                else nq--;
                random_count++;
            end
            push_request(pmc_pkg::OP_MUL, pick_coeff());
            random_count++;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the driver to empty and every product to come back.
        while (pending_requests.size() > 0 || i_start) @(posedge i_clk);
        while (expected_terms.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_terms.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_terms.size()));
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
